[hdl/wht_pkg.sv]
package wht_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 19;

  // default transform capacity
  localparam int MAX_POINTS_DEF = 64;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int ORDER_W    = 2;
  localparam int LOG_REG_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORDERING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 1'd1;

  localparam logic [LOG_REG_W-1:0] LOG_SIZE_RESET = 3'd6;

  // output order codes
  localparam logic [ORDER_W-1:0] ORD_NATURAL  = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_SEQUENCY = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_PALEY    = 2'd2;
  localparam logic [ORDER_W-1:0] ORD_BITREV   = 2'd3;

  // scaling: q15 multiplier, 1/sqrt(2) for odd log size, unity for even
  localparam int FRAC_W = 15;
  localparam int MULT_W = 17;
  localparam logic [MULT_W-1:0] INV_SQRT2_Q15 = 17'd23170;
  localparam logic [MULT_W-1:0] UNITY_Q15     = 17'd32768;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_BF_READ,
    ST_BF_WRITE,
    ST_EMIT
  } wht_state_t;

  // read issued toward the scaling pipeline
  typedef struct packed {
    logic issue;
    logic last;
  } wht_rd_t;

endpackage

[hdl/wht_ram.sv]
module wht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             a_en,
  input  logic             a_we,
  input  logic [AW-1:0]    a_addr,
  input  logic [WIDTH-1:0] a_wdata,
  output logic [WIDTH-1:0] a_rdata,
  input  logic             b_en,
  input  logic             b_we,
  input  logic [AW-1:0]    b_addr,
  input  logic [WIDTH-1:0] b_wdata,
  output logic [WIDTH-1:0] b_rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data only updates on a read, so it holds until the next one
  always_ff @(posedge clk) begin
    if (a_en) begin
      if (a_we) begin
        mem[a_addr] <= a_wdata;
      end else begin
        a_rdata <= mem[a_addr];
      end
    end
    if (b_en) begin
      if (b_we) begin
        mem[b_addr] <= b_wdata;
      end else begin
        b_rdata <= mem[b_addr];
      end
    end
  end

endmodule

[hdl/wht_seq.sv]
module wht_seq #(
  parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF,
  localparam int ADDR_W = $clog2(MAX_POINTS),
  localparam int DATA_W = wht_pkg::SAMPLE_W + ADDR_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [wht_pkg::SAMPLE_W-1:0] sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                ram_a_en,
  output logic                                ram_a_we,
  output logic [ADDR_W-1:0]                   ram_a_addr,
  output logic [DATA_W-1:0]                   ram_a_wdata,
  input  logic [DATA_W-1:0]                   ram_a_rdata,
  output logic                                ram_b_en,
  output logic                                ram_b_we,
  output logic [ADDR_W-1:0]                   ram_b_addr,
  output logic [DATA_W-1:0]                   ram_b_wdata,
  input  logic [DATA_W-1:0]                   ram_b_rdata,
  output wht_pkg::wht_rd_t                    rd,
  input  logic                                rd_free,
  output logic [wht_pkg::LOG_REG_W-1:0]       used_log
);

  localparam int CNT_W   = ADDR_W + 1;
  localparam int LOG_CAP = (ADDR_W > 7) ? 7 : ADDR_W;
  localparam int SH_W    = $clog2(ADDR_W + 1);

  wht_pkg::wht_state_t state, state_next;

  logic [wht_pkg::ORDER_W-1:0]   ordering;
  logic [wht_pkg::LOG_REG_W-1:0] log_size;
  logic [CNT_W-1:0]              load_count;
  logic [wht_pkg::LOG_REG_W-1:0] stage;
  logic [ADDR_W-1:0]             bfly;
  logic [CNT_W-1:0]              out_count;

  logic [CNT_W-1:0]  n_pts;
  logic [CNT_W-1:0]  load_idx;
  logic              load_done;
  logic              sample_acc;
  logic [ADDR_W-1:0] half_bit;
  logic [ADDR_W-1:0] half_mask;
  logic [ADDR_W-1:0] addr_lo;
  logic [ADDR_W-1:0] addr_hi;
  logic              bfly_last;
  logic              stage_last;
  logic              emit_go;
  logic              emit_last;
  logic [ADDR_W-1:0] emit_idx;
  logic [SH_W-1:0]   rev_shift;
  logic [ADDR_W-1:0] src_addr;

  function automatic logic [ADDR_W-1:0] rev_bits(input logic [ADDR_W-1:0] x);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = x[ADDR_W-1-i];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  assign used_log = (log_size > wht_pkg::LOG_REG_W'(LOG_CAP)) ?
                    wht_pkg::LOG_REG_W'(LOG_CAP) : log_size;
  assign n_pts    = CNT_W'(1) << used_log;

  assign load_idx     = (load_count >= n_pts) ? '0 : load_count;
  assign load_done    = (load_idx + CNT_W'(1)) == n_pts;
  assign sample_stall = (state != wht_pkg::ST_LOAD);
  assign sample_acc   = sample_valid && !sample_stall;

  // butterfly pair: insert a zero bit at the stage position
  assign half_bit   = ADDR_W'(1) << stage;
  assign half_mask  = half_bit - ADDR_W'(1);
  assign addr_lo    = ((bfly & ~half_mask) << 1) | (bfly & half_mask);
  assign addr_hi    = addr_lo | half_bit;
  assign bfly_last  = bfly == ADDR_W'((n_pts >> 1) - CNT_W'(1));
  assign stage_last = stage == (used_log - wht_pkg::LOG_REG_W'(1));

  assign emit_go   = (state == wht_pkg::ST_EMIT) && rd_free;
  assign emit_last = out_count == (n_pts - CNT_W'(1));
  assign emit_idx  = out_count[ADDR_W-1:0];
  assign rev_shift = SH_W'(ADDR_W) - SH_W'(used_log);

  always_comb begin
    case (ordering)
      wht_pkg::ORD_NATURAL:  src_addr = emit_idx;
      wht_pkg::ORD_SEQUENCY: src_addr = rev_bits(emit_idx ^ (emit_idx >> 1)) >> rev_shift;
      wht_pkg::ORD_PALEY,
      wht_pkg::ORD_BITREV:   src_addr = rev_bits(emit_idx) >> rev_shift;
      default:               src_addr = emit_idx;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      wht_pkg::ST_LOAD: begin
        if (sample_acc && load_done) begin
          state_next = (used_log == '0) ? wht_pkg::ST_EMIT : wht_pkg::ST_BF_READ;
        end
      end
      wht_pkg::ST_BF_READ: begin
        // port b read data still feeds a waiting coefficient until rd_free
        if (rd_free) begin
          state_next = wht_pkg::ST_BF_WRITE;
        end
      end
      wht_pkg::ST_BF_WRITE: begin
        if (bfly_last && stage_last) begin
          state_next = wht_pkg::ST_EMIT;
        end else begin
          state_next = wht_pkg::ST_BF_READ;
        end
      end
      wht_pkg::ST_EMIT: begin
        if (emit_go && emit_last) begin
          state_next = wht_pkg::ST_LOAD;
        end
      end
      default: state_next = wht_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    ram_a_en    = 1'b0;
    ram_a_we    = 1'b0;
    ram_a_addr  = addr_lo;
    ram_a_wdata = ram_a_rdata + ram_b_rdata;
    ram_b_en    = 1'b0;
    ram_b_we    = 1'b0;
    ram_b_addr  = addr_hi;
    ram_b_wdata = ram_a_rdata - ram_b_rdata;
    rd.issue    = 1'b0;
    rd.last     = emit_last;
    case (state)
      wht_pkg::ST_LOAD: begin
        ram_a_en    = sample_acc;
        ram_a_we    = sample_acc;
        ram_a_addr  = load_idx[ADDR_W-1:0];
        ram_a_wdata = {{(DATA_W - wht_pkg::SAMPLE_W){sample[wht_pkg::SAMPLE_W-1]}}, sample};
      end
      wht_pkg::ST_BF_READ: begin
        ram_a_en = rd_free;
        ram_b_en = rd_free;
      end
      wht_pkg::ST_BF_WRITE: begin
        ram_a_en = 1'b1;
        ram_a_we = 1'b1;
        ram_b_en = 1'b1;
        ram_b_we = 1'b1;
      end
      wht_pkg::ST_EMIT: begin
        ram_b_en   = emit_go;
        ram_b_addr = src_addr;
        rd.issue   = emit_go;
      end
      default: begin
        ram_a_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wht_pkg::ST_LOAD;
      ordering   <= wht_pkg::ORD_NATURAL;
      log_size   <= wht_pkg::LOG_SIZE_RESET;
      load_count <= '0;
      stage      <= '0;
      bfly       <= '0;
      out_count  <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wht_pkg::REG_ORDERING: ordering <= cfg_data[wht_pkg::ORDER_W-1:0];
          wht_pkg::REG_LOG_SIZE: log_size <= cfg_data;
          default: ordering <= ordering;
        endcase
      end

      // a new length drops the partial frame
      if (cfg_valid && cfg_ready && cfg_index == wht_pkg::REG_LOG_SIZE) begin
        load_count <= '0;
      end else if (sample_acc) begin
        load_count <= load_done ? '0 : load_idx + CNT_W'(1);
      end

      if (state == wht_pkg::ST_BF_WRITE) begin
        if (bfly_last) begin
          bfly  <= '0;
          stage <= stage_last ? '0 : stage + wht_pkg::LOG_REG_W'(1);
        end else begin
          bfly <= bfly + ADDR_W'(1);
        end
      end

      if (emit_go) begin
        out_count <= emit_last ? '0 : out_count + CNT_W'(1);
      end
    end
  end

endmodule

[hdl/wht_scale.sv]
module wht_scale #(
  parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF,
  localparam int DATA_W = wht_pkg::SAMPLE_W + $clog2(MAX_POINTS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wht_pkg::wht_rd_t                  rd,
  output logic                              rd_free,
  input  logic [DATA_W-1:0]                 rdata,
  input  logic [wht_pkg::LOG_REG_W-1:0]     used_log,
  output logic signed [wht_pkg::COEF_W-1:0] coefficient,
  output logic                              last,
  output logic                              result_valid,
  input  logic                              result_stall
);

  localparam int P_W  = DATA_W + wht_pkg::MULT_W;
  localparam int R_W  = P_W + 1;
  localparam int SH_W = 5;

  logic                        v1, last1;
  logic                        v2, last2;
  logic signed [P_W-1:0]       prod;
  logic [wht_pkg::MULT_W-1:0]  mul_k;
  logic [SH_W-1:0]             shift;
  logic [R_W-1:0]              round_bit;
  logic signed [R_W-1:0]       sum_r;
  logic signed [R_W-1:0]       rounded;
  logic                        fits;
  logic [wht_pkg::COEF_W-1:0]  coef_sat;
  logic                        out_free, s2_go, s2_free, s1_go;

  assign out_free = !result_valid || !result_stall;
  assign s2_go    = v2 && out_free;
  assign s2_free  = !v2 || s2_go;
  assign s1_go    = v1 && s2_free;
  assign rd_free  = !v1 || s1_go;

  // odd log size folds in 1/sqrt(2), the shift takes the rest of 1/sqrt(n)
  assign mul_k     = used_log[0] ? wht_pkg::INV_SQRT2_Q15 : wht_pkg::UNITY_Q15;
  assign shift     = SH_W'(wht_pkg::FRAC_W) + SH_W'(used_log >> 1);
  assign round_bit = R_W'(1) << (shift - SH_W'(1));
  assign sum_r     = $signed({prod[P_W-1], prod}) + $signed(round_bit);
  assign rounded   = sum_r >>> shift;

  assign fits = (&rounded[R_W-1:wht_pkg::COEF_W-1]) || !(|rounded[R_W-1:wht_pkg::COEF_W-1]);
  assign coef_sat = fits ? rounded[wht_pkg::COEF_W-1:0] :
                    rounded[R_W-1] ? {1'b1, {(wht_pkg::COEF_W-1){1'b0}}} :
                                     {1'b0, {(wht_pkg::COEF_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      prod  <= $signed(rdata) * $signed(mul_k);
      last2 <= last1;
    end
    if (rd.issue) begin
      last1 <= rd.last;
    end
    if (s2_go) begin
      coefficient <= coef_sat;
      last        <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rd.issue) begin
        v1 <= 1'b1;
      end else if (s1_go) begin
        v1 <= 1'b0;
      end
      if (s1_go) begin
        v2 <= 1'b1;
      end else if (s2_go) begin
        v2 <= 1'b0;
      end
      if (s2_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/walsh_hadamard_transform.sv]
// after the last sample transfer, all butterfly passes run before the read-out
// each butterfly takes a read state and a write state on the dual-port buffer;
//   samples stall from the end of a load until the last coefficient read issues
// coefficients stream one per cycle unless stalled, via a three-stage scale pipe
// reset: synchronous, clears control, ordering = natural, log_size = 6;
//   buffer contents stay undefined until written
module walsh_hadamard_transform #(
  parameter int MAX_POINTS = wht_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [wht_pkg::SAMPLE_W-1:0] sample,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [wht_pkg::COEF_W-1:0]   coefficient,
  output logic                                last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  // samples grow one bit per butterfly stage
  localparam int DATA_W = wht_pkg::SAMPLE_W + ADDR_W;

  // buffer ports: a carries sample loads and the upper butterfly leg,
  // b carries the lower leg and the coefficient reads
  logic              ram_a_en, ram_a_we;
  logic [ADDR_W-1:0] ram_a_addr;
  logic [DATA_W-1:0] ram_a_wdata, ram_a_rdata;
  logic              ram_b_en, ram_b_we;
  logic [ADDR_W-1:0] ram_b_addr;
  logic [DATA_W-1:0] ram_b_wdata, ram_b_rdata;

  wht_pkg::wht_rd_t              rd;
  logic                          rd_free;
  logic [wht_pkg::LOG_REG_W-1:0] used_log;

  // sequencer: load, in-place butterflies, ordered read-out
  wht_seq #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ram_a_en     (ram_a_en),
    .ram_a_we     (ram_a_we),
    .ram_a_addr   (ram_a_addr),
    .ram_a_wdata  (ram_a_wdata),
    .ram_a_rdata  (ram_a_rdata),
    .ram_b_en     (ram_b_en),
    .ram_b_we     (ram_b_we),
    .ram_b_addr   (ram_b_addr),
    .ram_b_wdata  (ram_b_wdata),
    .ram_b_rdata  (ram_b_rdata),
    .rd           (rd),
    .rd_free      (rd_free),
    .used_log     (used_log)
  );

  // work buffer, one entry per point
  wht_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_buf (
    .clk     (clk),
    .a_en    (ram_a_en),
    .a_we    (ram_a_we),
    .a_addr  (ram_a_addr),
    .a_wdata (ram_a_wdata),
    .a_rdata (ram_a_rdata),
    .b_en    (ram_b_en),
    .b_we    (ram_b_we),
    .b_addr  (ram_b_addr),
    .b_wdata (ram_b_wdata),
    .b_rdata (ram_b_rdata)
  );

  // 1/sqrt(n) scaling, round half up, saturate, output register
  wht_scale #(
    .MAX_POINTS (MAX_POINTS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .rd           (rd),
    .rd_free      (rd_free),
    .rdata        (ram_b_rdata),
    .used_log     (used_log),
    .coefficient  (coefficient),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
